### src/tfd_pkg.sv
// Package for the tagged frame decoder: payload types, status codes and constants.
`default_nettype none

package tfd_pkg;

    localparam int CAPTURE_BYTES_DEF = 16;
    localparam int CNT_W             = 9;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [CFG_IDX_W-1:0] REG_ACK_TAG       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMPEDANCE_TAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID_TAG = 2'd2;

    localparam logic [2:0] STATUS_FRAME_ERROR   = 3'd0;
    localparam logic [2:0] STATUS_ACK           = 3'd1;
    localparam logic [2:0] STATUS_IMP_LONG      = 3'd2;
    localparam logic [2:0] STATUS_IMP_SHORT     = 3'd3;
    localparam logic [2:0] STATUS_DEVICE_ID     = 3'd4;
    localparam logic [2:0] STATUS_UNKNOWN_TAG   = 3'd5;
    localparam logic [2:0] STATUS_BAD_LENGTH    = 3'd6;

    localparam logic [CNT_W-1:0] ACK_PLEN       = 9'd1;
    localparam logic [CNT_W-1:0] IMP_LONG_PLEN  = 9'd16;
    localparam logic [CNT_W-1:0] IMP_SHORT_PLEN = 9'd10;
    localparam logic [CNT_W-1:0] DEV_MIN_PLEN   = 9'd7;
    localparam logic [CNT_W-1:0] FRAME_OVERHEAD = 9'd3;

    localparam logic [31:0] SHORT_TIMESTAMP = 32'hBF80_0000; // -1.0
    localparam logic [15:0] SHORT_CHANNEL   = 16'hFFFF;      // -1
    localparam logic [11:0] YEAR_BASE       = 12'd2010;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         ack_code;
        logic signed [15:0] freq_number;
        logic [31:0]        timestamp_bits;
        logic signed [15:0] channel_number;
        logic [31:0]        real_bits;
        logic [31:0]        imag_bits;
        logic [7:0]         format_version;
        logic signed [15:0] device_identifier;
        logic signed [15:0] serial_number;
        logic [11:0]        delivery_year;
        logic [7:0]         delivery_month;
    } out_item_t;

endpackage

`default_nettype wire

### src/tagged_frame_decoder.sv
// Tagged frame decoder: byte counting, payload capture, frame check and decode.
//
// Bytes enter on in_valid/in_stall/in_data, one transaction per byte, with
// frame_end set on the closing tag byte. A transaction completes when valid is
// high and stall is low. Each frame (tag, length, payload, tag) yields one
// result on out_valid/out_stall/out_data; bytes without frame_end yield none.
// The tag registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Index 0 is the ack tag, 1 the impedance tag, 2 the device id tag, and index 3 is ignored.
// Throughput is one byte per cycle while in_stall is low: the frame check and
// decode sit between the per-frame state registers and the result register.
// A finished result is registered in the output register, or in the skid register.
// A stalled result is held in the output register; a second finished result
// goes to a skid register, and in_stall rises only while that skid register is
// full, so bytes keep flowing during a one-result backlog.
// Reset clears the byte counter, the stored tag and length bytes, the tag
// registers and both result valid flags. The payload capture is not reset.
`default_nettype none

module tagged_frame_decoder #(
    parameter int CAPTURE_BYTES = tfd_pkg::CAPTURE_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire tfd_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output tfd_pkg::out_item_t                  out_data
);

    localparam int CNT_W = tfd_pkg::CNT_W;

    logic [7:0] ack_tag_reg;
    logic [7:0] impedance_tag_reg;
    logic [7:0] device_id_tag_reg;

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [7:0]       first_tag_reg;
    logic [7:0]       length_byte_reg;
    logic [7:0]       capture_reg [CAPTURE_BYTES];

    logic               out_valid_reg;
    tfd_pkg::out_item_t out_data_reg;
    logic               skid_valid_reg;
    tfd_pkg::out_item_t skid_data_reg;

    logic               in_fire;
    logic               push;
    logic               pop;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   plen;
    logic               frame_bad;
    tfd_pkg::out_item_t result;
    logic [7:0]         pb [16];

    assign in_fire = in_valid && !in_stall;
    assign push    = in_fire && in_data.frame_end;
    assign pop     = out_valid_reg && !out_stall;

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_tag_reg       <= '0;
            impedance_tag_reg <= '0;
            device_id_tag_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tfd_pkg::REG_ACK_TAG:       ack_tag_reg       <= cfg_data;
                tfd_pkg::REG_IMPEDANCE_TAG: impedance_tag_reg <= cfg_data;
                tfd_pkg::REG_DEVICE_ID_TAG: device_id_tag_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // byte counter saturates at its maximum, frame_end restarts it
    assign total = (byte_count_reg < tfd_pkg::COUNT_MAX) ?
                   byte_count_reg + CNT_W'(1) : tfd_pkg::COUNT_MAX;
    assign byte_count_next = in_data.frame_end ? '0 : total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            first_tag_reg   <= '0;
            length_byte_reg <= '0;
        end
        else if (in_fire)
        begin
            byte_count_reg <= byte_count_next;
            if (byte_count_reg == CNT_W'(0))
            begin
                first_tag_reg <= in_data.data_byte;
            end
            if (byte_count_reg == CNT_W'(1))
            begin
                length_byte_reg <= in_data.data_byte;
            end
        end
    end

    for (genvar i = 0; i < CAPTURE_BYTES; i++)
    begin : g_capture
        always_ff @(posedge clk)
        begin
            if (in_fire && byte_count_reg == CNT_W'(i + 2))
            begin
                capture_reg[i] <= in_data.data_byte;
            end
        end
    end

    // the decode reads only the first sixteen payload bytes
    for (genvar i = 0; i < 16; i++)
    begin : g_pb
        assign pb[i] = capture_reg[i];
    end

    // The closing byte lands past every entry the decode reads, so the decode
    // can use the stored bytes directly.
    assign plen      = total - tfd_pkg::FRAME_OVERHEAD;
    assign frame_bad = (total < tfd_pkg::FRAME_OVERHEAD)
                    || (first_tag_reg != in_data.data_byte)
                    || ({1'b0, length_byte_reg} != plen);

    always_comb
    begin
        result        = '0;
        result.status = tfd_pkg::STATUS_FRAME_ERROR;
        priority if (frame_bad)
        begin
            result.status = tfd_pkg::STATUS_FRAME_ERROR;
        end
        else if (first_tag_reg == ack_tag_reg)
        begin
            if (plen == tfd_pkg::ACK_PLEN)
            begin
                result.status   = tfd_pkg::STATUS_ACK;
                result.ack_code = pb[0];
            end
            else
            begin
                result.status = tfd_pkg::STATUS_BAD_LENGTH;
            end
        end
        else if (first_tag_reg == impedance_tag_reg)
        begin
            if (plen == tfd_pkg::IMP_LONG_PLEN)
            begin
                result.status         = tfd_pkg::STATUS_IMP_LONG;
                result.freq_number    = {pb[0], pb[1]};
                result.timestamp_bits = {pb[2], pb[3], pb[4], pb[5]};
                result.channel_number = {pb[6], pb[7]};
                result.real_bits      = {pb[8], pb[9], pb[10], pb[11]};
                result.imag_bits      = {pb[12], pb[13], pb[14], pb[15]};
            end
            else if (plen == tfd_pkg::IMP_SHORT_PLEN)
            begin
                result.status         = tfd_pkg::STATUS_IMP_SHORT;
                result.freq_number    = {pb[0], pb[1]};
                result.timestamp_bits = tfd_pkg::SHORT_TIMESTAMP;
                result.channel_number = tfd_pkg::SHORT_CHANNEL;
                result.real_bits      = {pb[2], pb[3], pb[4], pb[5]};
                result.imag_bits      = {pb[6], pb[7], pb[8], pb[9]};
            end
            else
            begin
                result.status = tfd_pkg::STATUS_BAD_LENGTH;
            end
        end
        else if (first_tag_reg == device_id_tag_reg)
        begin
            if (plen >= tfd_pkg::DEV_MIN_PLEN)
            begin
                result.status            = tfd_pkg::STATUS_DEVICE_ID;
                result.format_version    = pb[0];
                result.device_identifier = {pb[1], pb[2]};
                result.serial_number     = {pb[3], pb[4]};
                result.delivery_year     = {4'd0, pb[5]} + tfd_pkg::YEAR_BASE;
                result.delivery_month    = pb[6];
            end
            else
            begin
                result.status = tfd_pkg::STATUS_BAD_LENGTH;
            end
        end
        else
        begin
            result.status = tfd_pkg::STATUS_UNKNOWN_TAG;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= result;
            end
        end
        else if (push)
        begin
            skid_data_reg <= result;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> byte_count_reg == '0)
        else $error("byte counter not cleared after frame end");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_data.frame_end && byte_count_reg < tfd_pkg::COUNT_MAX)
        |=> byte_count_reg == $past(byte_count_reg) + CNT_W'(1))
        else $error("byte counter did not advance");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.status <= tfd_pkg::STATUS_BAD_LENGTH)
        else $error("status code out of range");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && push) |=> skid_valid_reg)
        else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

### bench/tfd_result_checker.sv
// Result checker for the tagged frame decoder: mirrors the frame state, predicts and compares.
`timescale 1ns / 1ps

module tfd_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  tfd_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  tfd_pkg::out_item_t             out_data,
    output int                             error_count,
    output int                             outstanding,
    output int                             results_seen
);

    import tfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // mirrored tag registers
    logic [7:0] ack_tag_q;
    logic [7:0] imp_tag_q;
    logic [7:0] dev_tag_q;

    // mirrored frame state
    logic [CNT_W-1:0] count_q;
    logic [7:0]       tag_q;
    logic [7:0]       len_q;
    logic [7:0]       capture [CAPTURE_BYTES_DEF];

    out_item_t decoded_frames [$];

    function automatic logic [15:0] cap16(input int i);
        return {capture[i], capture[i+1]};
    endfunction

    function automatic logic [31:0] cap32(input int i);
        return {capture[i], capture[i+1], capture[i+2], capture[i+3]};
    endfunction

    task automatic decode_byte(input in_item_t item);
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] plen;
        out_item_t        res;
        if (count_q == '0)
            tag_q = item.data_byte;
        else if (count_q == 9'd1)
            len_q = item.data_byte;
        else if ((count_q - 2) < CAPTURE_BYTES_DEF)
            capture[count_q - 2] = item.data_byte;

        total = (count_q < COUNT_MAX) ? count_q + 9'd1 : COUNT_MAX;

        if (!item.frame_end)
        begin
            count_q = total;
        end
        else
        begin
            count_q = '0;
            res = '0;
            if (total < FRAME_OVERHEAD || tag_q != item.data_byte
                    || {1'b0, len_q} != total - FRAME_OVERHEAD)
            begin
                res.status = STATUS_FRAME_ERROR;
            end
            else
            begin
                plen = total - FRAME_OVERHEAD;
                // tag priority when registers share a value: ack, impedance, device id
                if (tag_q == ack_tag_q)
                begin
                    if (plen == ACK_PLEN)
                    begin
                        res.status   = STATUS_ACK;
                        res.ack_code = capture[0];
                    end
                    else
                    begin
                        res.status = STATUS_BAD_LENGTH;
                    end
                end
                else if (tag_q == imp_tag_q)
                begin
                    if (plen == IMP_LONG_PLEN)
                    begin
                        res.status         = STATUS_IMP_LONG;
                        res.freq_number    = cap16(0);
                        res.timestamp_bits = cap32(2);
                        res.channel_number = cap16(6);
                        res.real_bits      = cap32(8);
                        res.imag_bits      = cap32(12);
                    end
                    else if (plen == IMP_SHORT_PLEN)
                    begin
                        res.status         = STATUS_IMP_SHORT;
                        res.freq_number    = cap16(0);
                        res.timestamp_bits = SHORT_TIMESTAMP;
                        res.channel_number = SHORT_CHANNEL;
                        res.real_bits      = cap32(2);
                        res.imag_bits      = cap32(6);
                    end
                    else
                    begin
                        res.status = STATUS_BAD_LENGTH;
                    end
                end
                else if (tag_q == dev_tag_q)
                begin
                    if (plen >= DEV_MIN_PLEN)
                    begin
                        res.status            = STATUS_DEVICE_ID;
                        res.format_version    = capture[0];
                        res.device_identifier = cap16(1);
                        res.serial_number     = cap16(3);
                        res.delivery_year     = {4'b0, capture[5]} + YEAR_BASE;
                        res.delivery_month    = capture[6];
                    end
                    else
                    begin
                        res.status = STATUS_BAD_LENGTH;
                    end
                end
                else
                begin
                    res.status = STATUS_UNKNOWN_TAG;
                end
            end
            decoded_frames.insert(decoded_frames.size(), res);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (error_count < REPORT_LIMIT)
                $display("[%0t] result %0d: %s expected %h, got %h",
                         $realtime, results_seen, name, want, got);
            error_count++;
        end
    endtask

    task automatic compare_result(input out_item_t want, input out_item_t got);
        check_field("status", want.status, got.status);
        check_field("ack_code", want.ack_code, got.ack_code);
        check_field("freq_number", want.freq_number, got.freq_number);
        check_field("timestamp_bits", want.timestamp_bits, got.timestamp_bits);
        check_field("channel_number", want.channel_number, got.channel_number);
        check_field("real_bits", want.real_bits, got.real_bits);
        check_field("imag_bits", want.imag_bits, got.imag_bits);
        check_field("format_version", want.format_version, got.format_version);
        check_field("device_identifier", want.device_identifier, got.device_identifier);
        check_field("serial_number", want.serial_number, got.serial_number);
        check_field("delivery_year", want.delivery_year, got.delivery_year);
        check_field("delivery_month", want.delivery_month, got.delivery_month);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_tag_q    = '0;
            imp_tag_q    = '0;
            dev_tag_q    = '0;
            count_q      = '0;
            tag_q        = '0;
            len_q        = '0;
            error_count  = 0;
            results_seen = 0;
            decoded_frames.delete();
            outstanding  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(in_data);

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ACK_TAG:       ack_tag_q = cfg_data;
                    REG_IMPEDANCE_TAG: imp_tag_q = cfg_data;
                    REG_DEVICE_ID_TAG: dev_tag_q = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (decoded_frames.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("[%0t] result with no frame pending, status %0d",
                                 $realtime, out_data.status);
                    error_count++;
                end
                else
                begin
                    compare_result(decoded_frames.pop_front(), out_data);
                end
                results_seen++;
            end
            outstanding = decoded_frames.size();
        end
    end

endmodule

### bench/tagged_frame_decoder_tb.sv
// Testbench top for the tagged frame decoder: clock, reset, byte stream stimulus and verdict.
`timescale 1ns / 1ps

module tagged_frame_decoder_tb;

    import tfd_pkg::*;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int RANDOM_BYTES_PER_PHASE = 90;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    int error_count;
    int outstanding;
    int results_seen;

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int frames_sent;

    logic [7:0] cur_ack_tag;
    logic [7:0] cur_imp_tag;
    logic [7:0] cur_dev_tag;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tagged_frame_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    tfd_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .error_count  (error_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Leaves cfg_write high; program_tags lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic program_tags(input logic [7:0] ack_v, input logic [7:0] imp_v,
                                input logic [7:0] dev_v);
        write_reg(REG_ACK_TAG, ack_v);
        write_reg(REG_IMPEDANCE_TAG, imp_v);
        write_reg(REG_DEVICE_ID_TAG, dev_v);
        // unused index, must not disturb any tag
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_write <= 1'b0;
        @(negedge clk);
        cur_ack_tag = ack_v;
        cur_imp_tag = imp_v;
        cur_dev_tag = dev_v;
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic put_byte(input logic [7:0] value, input logic last);
        in_item_t item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        item.data_byte = value;
        item.frame_end = last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
        if (last)
            frames_sent++;
    endtask

    task automatic send_frame(input logic [7:0] tag, input logic [7:0] len_field,
                              input int plen, input logic [7:0] tail, input int fill);
        logic [7:0] b;
        put_byte(tag, 1'b0);
        put_byte(len_field, 1'b0);
        for (int i = 0; i < plen; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            put_byte(b, 1'b0);
        end
        put_byte(tail, 1'b1);
    endtask

    // Wait for every result, then let the output path empty before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_frame();
        int         kind;
        int         pick;
        int         plen;
        logic [7:0] tag;
        logic [7:0] len_field;
        logic [7:0] tail;
        kind = $urandom_range(99);
        pick = $urandom_range(9);
        if (pick < 3)
        begin
            tag  = cur_ack_tag;
            plen = ($urandom_range(4) == 0) ? $urandom_range(20) : 1;
        end
        else if (pick < 6)
        begin
            tag  = cur_imp_tag;
            case ($urandom_range(9))
                0, 1, 2, 3: plen = 16;
                4, 5, 6, 7: plen = 10;
                default:    plen = $urandom_range(20);
            endcase
        end
        else if (pick < 9)
        begin
            tag  = cur_dev_tag;
            plen = ($urandom_range(9) == 0) ? $urandom_range(6) : 7 + $urandom_range(12);
        end
        else
        begin
            tag  = 8'($urandom);
            plen = $urandom_range(20);
        end
        len_field = 8'(plen);
        tail      = tag;

        if (kind >= 85)
        begin
            // noise: random length field, closing tag often wrong
            plen      = $urandom_range(30);
            len_field = 8'($urandom);
            if ($urandom_range(1) == 0)
                tail = 8'($urandom);
            send_frame(tag, len_field, plen, tail, FILL_RANDOM);
        end
        else if (kind >= 70)
        begin
            case ($urandom_range(2))
                0:
                begin
                    tail = tag ^ 8'($urandom_range(1, 255));
                    send_frame(tag, len_field, plen, tail, FILL_RANDOM);
                end
                1:
                begin
                    len_field = len_field + 8'($urandom_range(1, 255));
                    send_frame(tag, len_field, plen, tail, FILL_RANDOM);
                end
                default:
                begin
                    // frame shorter than tag, length, tag
                    if ($urandom_range(1) == 0)
                    begin
                        put_byte(tag, 1'b1);
                    end
                    else
                    begin
                        put_byte(tag, 1'b0);
                        put_byte(tail, 1'b1);
                    end
                end
            endcase
        end
        else
        begin
            send_frame(tag, len_field, plen, tail, FILL_RANDOM);
        end
    endtask

    initial
    begin
        logic [7:0] imp_v;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        frames_sent    = 0;
        cur_ack_tag    = 8'h00;
        cur_imp_tag    = 8'h00;
        cur_dev_tag    = 8'h00;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // tags all at reset value: ack wins the shared tag
        send_frame(8'h00, 8'd1, 1, 8'h00, FILL_ZERO);
        send_frame(8'h00, 8'd16, 16, 8'h00, FILL_RANDOM);
        put_byte(8'h00, 1'b1);
        put_byte(8'h5A, 1'b0);
        put_byte(8'h5A, 1'b1);
        send_frame(8'hFF, 8'd0, 0, 8'hFF, FILL_RANDOM);
        settle();

        program_tags(8'h01, 8'h02, 8'h03);
        send_frame(8'h01, 8'd1, 1, 8'h01, FILL_ONES);
        send_frame(8'h01, 8'd0, 0, 8'h01, FILL_RANDOM);
        send_frame(8'h01, 8'd2, 2, 8'h01, FILL_RANDOM);
        send_frame(8'h02, 8'd16, 16, 8'h02, FILL_ZERO);
        send_frame(8'h02, 8'd16, 16, 8'h02, FILL_ONES);
        send_frame(8'h02, 8'd10, 10, 8'h02, FILL_RANDOM);
        send_frame(8'h02, 8'd10, 10, 8'h02, FILL_ONES);
        send_frame(8'h02, 8'd12, 12, 8'h02, FILL_RANDOM);
        send_frame(8'h03, 8'd7, 7, 8'h03, FILL_ONES);
        send_frame(8'h03, 8'd7, 7, 8'h03, FILL_ZERO);
        send_frame(8'h03, 8'd6, 6, 8'h03, FILL_RANDOM);
        // payload well past the capture window
        send_frame(8'h03, 8'd40, 40, 8'h03, FILL_RANDOM);
        send_frame(8'h01, 8'd1, 1, 8'h02, FILL_RANDOM);
        send_frame(8'h02, 8'd15, 16, 8'h02, FILL_RANDOM);
        send_frame(8'h77, 8'd0, 0, 8'h77, FILL_RANDOM);
        settle();

        program_tags(8'hFF, 8'h00, 8'h80);
        send_frame(8'hFF, 8'd1, 1, 8'hFF, FILL_RANDOM);
        send_frame(8'h00, 8'd16, 16, 8'h00, FILL_RANDOM);
        send_frame(8'h80, 8'd7, 7, 8'h80, FILL_RANDOM);
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            int phase_start;
            imp_v = 8'($urandom);
            // one phase has impedance and device id sharing a tag
            program_tags(8'($urandom), imp_v, (phase == 2) ? imp_v : 8'($urandom));
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES_PER_PHASE)
                random_frame();
            settle();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        repeat (8) @(negedge clk);
        $display("Covered %0d bytes in %0d frames, %0d results checked,",
                 bytes_sent, frames_sent, results_seen);
        $display("across reset, extreme, shared and random tag settings with four idle mixes.");
        if (outstanding != 0)
            $display("%0d decoded frames never came out", outstanding);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d bytes sent, %0d results outstanding", bytes_sent, outstanding);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
